[rtl/rgb_integral_image_square_stats_macros.svh]
// Assertion macros for the summed-area statistics block.
`ifndef RGB_INTEGRAL_IMAGE_SQUARE_STATS_MACROS_SVH
`define RGB_INTEGRAL_IMAGE_SQUARE_STATS_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define RGBSAT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define RGBSAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RGBSAT_ASSERT_SAME(label, ante, cons, msg)
`define RGBSAT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[rtl/rgbsat_pkg.sv]
// Shared types and constants of the summed-area statistics block.
package rgbsat_pkg;

  localparam int PIX_W     = 8;
  localparam int COORD_W   = 9;
  localparam int SIDE_W    = 4;
  localparam int DIM_REG_W = 10;
  localparam int CFG_IDX_W = 2;
  localparam int STATUS_W  = 2;
  localparam int SUM_OUT_W = 26;
  localparam int SQ_OUT_W  = 34;
  localparam int VAR_W     = 54;
  localparam int DIM_RESET = 512;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_RANGE      = 2'd1,
    ST_NOT_LOADED = 2'd2
  } status_t;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // Corners of a box: bottom-right is added, bottom-left and top-right are
  // subtracted, top-left is added back.
  typedef enum logic [1:0] {
    CORNER_BR = 2'd0,
    CORNER_BL = 2'd1,
    CORNER_TR = 2'd2,
    CORNER_TL = 2'd3
  } corner_t;

  typedef struct packed {
    logic    ld_start;
    logic    ld_write;
    logic    q_start;
    logic    rd_en;
    corner_t corner;
    logic    mul_en;
    logic [1:0] mul_ch;
    logic    var_en;
    logic    out_load;
    status_t out_status;
  } cmd_t;

  typedef struct packed {
    logic loaded;
    logic query_fits;
  } sts_t;

endpackage

[rtl/rgbsat_ifs.sv]
// Handshake channel interfaces of the summed-area statistics block.
interface rgbsat_req_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic [rgbsat_pkg::PIX_W-1:0]      red;
  logic [rgbsat_pkg::PIX_W-1:0]      green;
  logic [rgbsat_pkg::PIX_W-1:0]      blue;
  logic [rgbsat_pkg::COORD_W-1:0]    corner_x;
  logic [rgbsat_pkg::COORD_W-1:0]    corner_y;
  logic [rgbsat_pkg::SIDE_W-1:0]     side_log2;

  modport source (output valid, action, red, green, blue, corner_x, corner_y, side_log2,
                  input ready);
  modport sink (input valid, action, red, green, blue, corner_x, corner_y, side_log2,
                output ready);
endinterface

interface rgbsat_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [rgbsat_pkg::STATUS_W-1:0]   status;
  logic [rgbsat_pkg::SUM_OUT_W-1:0]  sum_red;
  logic [rgbsat_pkg::SUM_OUT_W-1:0]  sum_green;
  logic [rgbsat_pkg::SUM_OUT_W-1:0]  sum_blue;
  logic [rgbsat_pkg::SQ_OUT_W-1:0]   sumsq_red;
  logic [rgbsat_pkg::SQ_OUT_W-1:0]   sumsq_green;
  logic [rgbsat_pkg::SQ_OUT_W-1:0]   sumsq_blue;
  logic [rgbsat_pkg::PIX_W-1:0]      avg_red;
  logic [rgbsat_pkg::PIX_W-1:0]      avg_green;
  logic [rgbsat_pkg::PIX_W-1:0]      avg_blue;
  logic [rgbsat_pkg::VAR_W-1:0]      scaled_variance;

  modport source (output valid, status, sum_red, sum_green, sum_blue, sumsq_red,
                  sumsq_green, sumsq_blue, avg_red, avg_green, avg_blue, scaled_variance,
                  input ready);
  modport sink (input valid, status, sum_red, sum_green, sum_blue, sumsq_red,
                sumsq_green, sumsq_blue, avg_red, avg_green, avg_blue, scaled_variance,
                output ready);
endinterface

interface rgbsat_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rgbsat_pkg::CFG_IDX_W-1:0]   index;
  logic [rgbsat_pkg::DIM_REG_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/rgbsat_ctrl.sv]
// Sequencer of the summed-area statistics block: loads, corner reads, result hand-off.
module rgbsat_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_action,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  rgbsat_pkg::sts_t   sts,
  output rgbsat_pkg::cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LD_WR = 5'b00010,
    S_Q_RD  = 5'b00100,
    S_Q_FIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  // Four corner reads, then five finishing steps: one for the last
  // accumulation, three squarings and one last variance update.
  localparam logic [2:0] LAST_CORNER = 3'd3;
  localparam logic [2:0] FIRST_MUL   = 3'd1;
  localparam logic [2:0] LAST_MUL    = 3'd3;
  localparam logic [2:0] FIRST_VAR   = 3'd2;
  localparam logic [2:0] LAST_FIN    = 3'd4;

  state_t                state, state_next;
  logic [2:0]            step, step_next;
  rgbsat_pkg::status_t   res_status, res_status_next;

  always_comb begin
    cmd             = '0;
    state_next      = state;
    step_next       = step;
    res_status_next = res_status;
    req_ready       = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          unique case (req_action)
            rgbsat_pkg::ACT_LOAD: begin
              // Pixels beyond the image are taken and dropped.
              if (!sts.loaded) begin
                cmd.ld_start = 1'b1;
                state_next   = S_LD_WR;
              end
            end
            rgbsat_pkg::ACT_QUERY: begin
              if (!sts.loaded) begin
                res_status_next = rgbsat_pkg::ST_NOT_LOADED;
                state_next      = S_DONE;
              end else if (!sts.query_fits) begin
                res_status_next = rgbsat_pkg::ST_RANGE;
                state_next      = S_DONE;
              end else begin
                res_status_next = rgbsat_pkg::ST_OK;
                cmd.q_start     = 1'b1;
                step_next       = '0;
                state_next      = S_Q_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_LD_WR: begin
        cmd.ld_write = 1'b1;
        state_next   = S_IDLE;
      end
      S_Q_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.corner = rgbsat_pkg::corner_t'(step[1:0]);
        if (step == LAST_CORNER) begin
          step_next  = '0;
          state_next = S_Q_FIN;
        end else begin
          step_next = step + 3'd1;
        end
      end
      S_Q_FIN: begin
        cmd.mul_en = (step >= FIRST_MUL) && (step <= LAST_MUL);
        cmd.mul_ch = 2'(step - FIRST_MUL);
        cmd.var_en = (step >= FIRST_VAR);
        if (step == LAST_FIN) begin
          step_next  = '0;
          state_next = S_DONE;
        end else begin
          step_next = step + 3'd1;
        end
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = res_status;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= '0;
      res_status <= rgbsat_pkg::ST_OK;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      step       <= step_next;
      res_status <= res_status_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/rgbsat_dp.sv]
// Datapath of the summed-area statistics block: tables, load sums, box sums, variance.
module rgbsat_dp #(
  parameter int MAX_WIDTH     = 512,
  parameter int MAX_HEIGHT    = 512,
  parameter int MAX_SIDE_LOG2 = 9
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rgbsat_pkg::cmd_t                    cmd,
  output rgbsat_pkg::sts_t                    sts,
  input  logic                                cfg_we,
  input  logic [rgbsat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rgbsat_pkg::DIM_REG_W-1:0]    cfg_data,
  input  logic [rgbsat_pkg::PIX_W-1:0]        red,
  input  logic [rgbsat_pkg::PIX_W-1:0]        green,
  input  logic [rgbsat_pkg::PIX_W-1:0]        blue,
  input  logic [rgbsat_pkg::COORD_W-1:0]      corner_x,
  input  logic [rgbsat_pkg::COORD_W-1:0]      corner_y,
  input  logic [rgbsat_pkg::SIDE_W-1:0]       side_log2,
  output logic [rgbsat_pkg::STATUS_W-1:0]     status,
  output logic [rgbsat_pkg::SUM_OUT_W-1:0]    sum_red,
  output logic [rgbsat_pkg::SUM_OUT_W-1:0]    sum_green,
  output logic [rgbsat_pkg::SUM_OUT_W-1:0]    sum_blue,
  output logic [rgbsat_pkg::SQ_OUT_W-1:0]     sumsq_red,
  output logic [rgbsat_pkg::SQ_OUT_W-1:0]     sumsq_green,
  output logic [rgbsat_pkg::SQ_OUT_W-1:0]     sumsq_blue,
  output logic [rgbsat_pkg::PIX_W-1:0]        avg_red,
  output logic [rgbsat_pkg::PIX_W-1:0]        avg_green,
  output logic [rgbsat_pkg::PIX_W-1:0]        avg_blue,
  output logic [rgbsat_pkg::VAR_W-1:0]        scaled_variance
);

  localparam int PW   = rgbsat_pkg::PIX_W;
  localparam int PSW  = 2 * PW;
  localparam int SOW  = rgbsat_pkg::SUM_OUT_W;
  localparam int QOW  = rgbsat_pkg::SQ_OUT_W;
  localparam int VW   = rgbsat_pkg::VAR_W;
  localparam int XW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XCW  = $clog2(MAX_WIDTH + 1);
  localparam int YCW  = $clog2(MAX_HEIGHT + 1);
  localparam int AW   = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam int SW   = PW + XW + YW;
  localparam int QW   = PSW + XW + YW;
  localparam int RSW  = PW + YW;
  localparam int RQW  = PSW + YW;
  localparam int M1   = (MAX_SIDE_LOG2 > rgbsat_pkg::COORD_W) ?
                        MAX_SIDE_LOG2 : rgbsat_pkg::COORD_W;
  localparam int M2   = (XCW > YCW) ? XCW : YCW;
  localparam int LW   = ((M1 > M2) ? M1 : M2) + 1;
  localparam logic [XCW-1:0] RESET_W =
    XCW'((MAX_WIDTH < rgbsat_pkg::DIM_RESET) ? MAX_WIDTH : rgbsat_pkg::DIM_RESET);
  localparam logic [YCW-1:0] RESET_H =
    YCW'((MAX_HEIGHT < rgbsat_pkg::DIM_RESET) ? MAX_HEIGHT : rgbsat_pkg::DIM_RESET);

  // Image size, already clamped to the supported range.
  logic [XCW-1:0]  w_eff;
  logic [YCW-1:0]  h_eff;
  logic [XCW-1:0]  clamp_w;
  logic [YCW-1:0]  clamp_h;
  logic            cfg_hit;

  // Load position and running column sums.
  logic [XCW-1:0]  col;
  logic [YCW-1:0]  row;
  logic [YCW-1:0]  row_inc;
  logic [RSW-1:0]  run_s      [3];
  logic [RQW-1:0]  run_q      [3];
  logic [RSW-1:0]  run_s_next [3];
  logic [RQW-1:0]  run_q_next [3];
  logic [PW-1:0]   pix        [3];
  logic [PSW-1:0]  pix_sq     [3];
  logic [SW-1:0]   left_s     [3];
  logic [QW-1:0]   left_q     [3];

  // Tables: one word holds the three channels.
  logic [3*SW-1:0] sum_mem [DEPTH];
  logic [3*QW-1:0] sq_mem  [DEPTH];
  logic [AW-1:0]   mem_addr;
  logic [3*SW-1:0] wsum;
  logic [3*QW-1:0] wsq;
  logic [3*SW-1:0] rd_sum;
  logic [3*QW-1:0] rd_sq;

  // Query state.
  logic [LW-1:0]                   side;
  logic [XW-1:0]                   ax1, ax0m1;
  logic [YW-1:0]                   ay1, ay0m1;
  logic                            x0nz, y0nz;
  logic [rgbsat_pkg::SIDE_W-1:0]   qd;
  logic [rgbsat_pkg::SIDE_W:0]     sh;
  logic                            acc_pend;
  rgbsat_pkg::corner_t             acc_corner;
  logic                            acc_use, acc_sub;
  logic [SW-1:0]                   acc_s [3];
  logic [QW-1:0]                   acc_q [3];
  logic [SW-1:0]                   sel_s;
  logic [QW-1:0]                   sel_q;
  logic [2*SW-1:0]                 sq_full;
  logic [VW-1:0]                   prod, qsh, var_acc;
  logic                            out_ok;
  logic [SOW-1:0]                  o_sum [3];
  logic [QOW-1:0]                  o_sq  [3];
  logic [PW-1:0]                   o_avg [3];

  // ---------------------------------------------------------------- config
  always_comb begin
    if (cfg_data == '0) begin
      clamp_w = XCW'(1);
    end else if (int'(cfg_data) > MAX_WIDTH) begin
      clamp_w = XCW'(MAX_WIDTH);
    end else begin
      clamp_w = XCW'(cfg_data);
    end
    if (cfg_data == '0) begin
      clamp_h = YCW'(1);
    end else if (int'(cfg_data) > MAX_HEIGHT) begin
      clamp_h = YCW'(MAX_HEIGHT);
    end else begin
      clamp_h = YCW'(cfg_data);
    end
  end

  assign cfg_hit = cfg_we && ((cfg_index == rgbsat_pkg::REG_IMAGE_WIDTH) ||
                              (cfg_index == rgbsat_pkg::REG_IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff <= RESET_W;
      h_eff <= RESET_H;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rgbsat_pkg::REG_IMAGE_WIDTH:  w_eff <= clamp_w;
        rgbsat_pkg::REG_IMAGE_HEIGHT: h_eff <= clamp_h;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------ load
  assign row_inc = YCW'(row + 1'b1);

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      pix_sq[ch]     = PSW'(pix[ch]) * PSW'(pix[ch]);
      run_s_next[ch] = run_s[ch] + RSW'(pix[ch]);
      run_q_next[ch] = run_q[ch] + RQW'(pix_sq[ch]);
      left_s[ch]     = (col == '0) ? '0 : rd_sum[ch*SW +: SW];
      left_q[ch]     = (col == '0) ? '0 : rd_sq[ch*QW +: QW];
      wsum[ch*SW +: SW] = left_s[ch] + SW'(run_s_next[ch]);
      wsq[ch*QW +: QW]  = left_q[ch] + QW'(run_q_next[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_start) begin
      pix[0] <= red;
      pix[1] <= green;
      pix[2] <= blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col <= '0;
      row <= '0;
      for (int ch = 0; ch < 3; ch++) begin
        run_s[ch] <= '0;
        run_q[ch] <= '0;
      end
    end else if (cmd.ld_write) begin
      if (row_inc >= h_eff) begin
        row <= '0;
        col <= XCW'(col + 1'b1);
        for (int ch = 0; ch < 3; ch++) begin
          run_s[ch] <= '0;
          run_q[ch] <= '0;
        end
      end else begin
        row <= row_inc;
        for (int ch = 0; ch < 3; ch++) begin
          run_s[ch] <= run_s_next[ch];
          run_q[ch] <= run_q_next[ch];
        end
      end
    end
  end

  assign sts.loaded = (col >= w_eff);

  // ---------------------------------------------------------------- tables
  always_comb begin
    mem_addr = {ax1, ay1};
    if (cmd.ld_start) begin
      mem_addr = {XW'(col - 1'b1), YW'(row)};
    end else if (cmd.ld_write) begin
      mem_addr = {XW'(col), YW'(row)};
    end else begin
      unique case (cmd.corner)
        rgbsat_pkg::CORNER_BR: mem_addr = {ax1, ay1};
        rgbsat_pkg::CORNER_BL: mem_addr = {ax0m1, ay1};
        rgbsat_pkg::CORNER_TR: mem_addr = {ax1, ay0m1};
        rgbsat_pkg::CORNER_TL: mem_addr = {ax0m1, ay0m1};
        default:               mem_addr = {ax1, ay1};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_write) begin
      sum_mem[mem_addr] <= wsum;
      sq_mem[mem_addr]  <= wsq;
    end
    rd_sum <= sum_mem[mem_addr];
    rd_sq  <= sq_mem[mem_addr];
  end

  // ----------------------------------------------------------------- query
  assign side = LW'(1) << side_log2;
  assign sts.query_fits = (int'(side_log2) <= MAX_SIDE_LOG2) &&
                          (LW'(corner_x) + side <= LW'(w_eff)) &&
                          (LW'(corner_y) + side <= LW'(h_eff));

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      ax1   <= XW'(LW'(corner_x) + side - LW'(1));
      ax0m1 <= XW'(LW'(corner_x) - LW'(1));
      ay1   <= YW'(LW'(corner_y) + side - LW'(1));
      ay0m1 <= YW'(LW'(corner_y) - LW'(1));
      x0nz  <= (corner_x != '0);
      y0nz  <= (corner_y != '0);
      qd    <= side_log2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_pend <= 1'b0;
    end else begin
      acc_pend <= cmd.rd_en;
    end
    acc_corner <= cmd.corner;
  end

  always_comb begin
    acc_use = 1'b0;
    acc_sub = 1'b0;
    unique case (acc_corner)
      rgbsat_pkg::CORNER_BR: acc_use = 1'b1;
      rgbsat_pkg::CORNER_BL: begin acc_use = x0nz; acc_sub = 1'b1; end
      rgbsat_pkg::CORNER_TR: begin acc_use = y0nz; acc_sub = 1'b1; end
      rgbsat_pkg::CORNER_TL: acc_use = x0nz && y0nz;
      default: ;
    endcase
    acc_use = acc_use && acc_pend;
  end

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      for (int ch = 0; ch < 3; ch++) begin
        acc_s[ch] <= '0;
        acc_q[ch] <= '0;
      end
    end else if (acc_use) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (acc_sub) begin
          acc_s[ch] <= acc_s[ch] - rd_sum[ch*SW +: SW];
          acc_q[ch] <= acc_q[ch] - rd_sq[ch*QW +: QW];
        end else begin
          acc_s[ch] <= acc_s[ch] + rd_sum[ch*SW +: SW];
          acc_q[ch] <= acc_q[ch] + rd_sq[ch*QW +: QW];
        end
      end
    end
  end

  // One shared squarer walks the three channels.
  always_comb begin
    case (cmd.mul_ch)
      rgbsat_pkg::CH_RED:   begin sel_s = acc_s[0]; sel_q = acc_q[0]; end
      rgbsat_pkg::CH_GREEN: begin sel_s = acc_s[1]; sel_q = acc_q[1]; end
      rgbsat_pkg::CH_BLUE:  begin sel_s = acc_s[2]; sel_q = acc_q[2]; end
      default:              begin sel_s = acc_s[2]; sel_q = acc_q[2]; end
    endcase
  end

  assign sh      = {qd, 1'b0};
  assign sq_full = (2*SW)'(sel_s) * (2*SW)'(sel_s);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= VW'(sq_full);
      qsh  <= VW'(sel_q) << sh;
    end
    if (cmd.q_start) begin
      var_acc <= '0;
    end else if (cmd.var_en) begin
      var_acc <= var_acc + qsh - prod;
    end
  end

  // ---------------------------------------------------------------- result
  assign out_ok = (cmd.out_status == rgbsat_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= cmd.out_status;
      for (int ch = 0; ch < 3; ch++) begin
        o_sum[ch] <= out_ok ? SOW'(acc_s[ch]) : '0;
        o_sq[ch]  <= out_ok ? QOW'(acc_q[ch]) : '0;
        o_avg[ch] <= out_ok ? PW'(acc_s[ch] >> sh) : '0;
      end
      scaled_variance <= out_ok ? var_acc : '0;
    end
  end

  assign sum_red     = o_sum[0];
  assign sum_green   = o_sum[1];
  assign sum_blue    = o_sum[2];
  assign sumsq_red   = o_sq[0];
  assign sumsq_green = o_sq[1];
  assign sumsq_blue  = o_sq[2];
  assign avg_red     = o_avg[0];
  assign avg_green   = o_avg[1];
  assign avg_blue    = o_avg[2];

endmodule

[rtl/rgb_integral_image_square_stats.sv]
// Top level of the RGB summed-area statistics block.
//
// Usage. The req channel carries items of two kinds. A load item (action 0)
// delivers the next pixel in column-major order: every row of column 0, then
// column 1, and so on. A query item (action 1) names a square by its top-left
// corner and the log2 of its side and produces exactly one item on the rsp
// channel; loads produce none. The cfg channel writes the image width
// (index 0) or height (index 1), is always ready, and restarts loading.
// A load is accepted in S_IDLE, where the left neighbour is read from the
// single-ported tables, and writes the new entry in S_LD_WR. A valid query
// goes through acceptance, four corner reads through the single memory port,
// five finishing steps around the one shared squarer and the hand-off to the
// output register; a rejected query goes straight to the hand-off. No new
// item is taken before the hand-off; the result shows on rsp the cycle after.
// Reset clears the load position and running sums and sets both sizes to 512
// or the maximum if smaller; the tables are not cleared, nor need to be.
// When the receiver stalls, the result waits in the output register while
// loads keep flowing; a further query completes and waits for that register.
`include "rgb_integral_image_square_stats_macros.svh"

module rgb_integral_image_square_stats #(
  parameter int MAX_WIDTH     = 512,
  parameter int MAX_HEIGHT    = 512,
  parameter int MAX_SIDE_LOG2 = 9
) (
  input  logic          clk,
  input  logic          rst,
  rgbsat_req_if.sink    req,
  rgbsat_rsp_if.source  rsp,
  rgbsat_cfg_if.sink    cfg
);

  rgbsat_pkg::cmd_t cmd;
  rgbsat_pkg::sts_t sts;
  logic             req_ready;
  logic             rsp_valid;

  // Configuration writes are taken whenever offered; the sender keeps them
  // to idle periods.
  assign cfg.ready = 1'b1;
  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;

  rgbsat_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_action (req.action),
    .req_ready  (req_ready),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // The datapath holds the tables, the load counters, the box accumulators
  // and the output register that parts the pipeline from the receiver.
  rgbsat_dp #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg.valid && cfg.ready),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .red             (req.red),
    .green           (req.green),
    .blue            (req.blue),
    .corner_x        (req.corner_x),
    .corner_y        (req.corner_y),
    .side_log2       (req.side_log2),
    .status          (rsp.status),
    .sum_red         (rsp.sum_red),
    .sum_green       (rsp.sum_green),
    .sum_blue        (rsp.sum_blue),
    .sumsq_red       (rsp.sumsq_red),
    .sumsq_green     (rsp.sumsq_green),
    .sumsq_blue      (rsp.sumsq_blue),
    .avg_red         (rsp.avg_red),
    .avg_green       (rsp.avg_green),
    .avg_blue        (rsp.avg_blue),
    .scaled_variance (rsp.scaled_variance)
  );

  // The request side is closed while corner reads are in flight.
  `RGBSAT_ASSERT_SAME(a_no_accept_in_query, cmd.rd_en, !req.ready, "item accepted during query")
  // A result is only moved into the output register once it is free.
  `RGBSAT_ASSERT_SAME(a_out_free, cmd.out_load, (!rsp.valid || rsp.ready), "result overwritten")
  // Every hand-off is presented in the following cycle.
  `RGBSAT_ASSERT_NEXT(a_out_shown, cmd.out_load, rsp.valid, "result not presented")
  // A successful result implies a fully loaded image.
  `RGBSAT_ASSERT_SAME(a_ok_loaded, (cmd.out_load && cmd.out_status == rgbsat_pkg::ST_OK), sts.loaded, "ok result before load completed")

endmodule
